// ----- rtl/akrt_pkg.sv -----
// Package: shared constants, codes and types for the analog key rapid trigger block.
`timescale 1ns / 1ps

package akrt_pkg;

   localparam int SAMPLE_BITS_DEF = 12;
   localparam int CAL_W           = 12;
   localparam int TRAVEL_W        = 8;
   localparam int THR_W           = 8;
   localparam int HYS_W           = 6;
   localparam int MODE_W          = 2;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 12;
   localparam int QUEUE_DEPTH     = 2;
   // scaled numerator and queue word widths at the default sample width
   localparam int NUM_W_DEF       = CAL_W + TRAVEL_W;
   localparam int ENTRY_W_DEF     = NUM_W_DEF + CAL_W + 2;

   localparam logic [TRAVEL_W-1:0] TRAVEL_MAX   = 8'hFF;
   localparam logic [TRAVEL_W-1:0] CONT_RELEASE = 8'd6;

   localparam logic [THR_W-1:0]  THR_RESET  = 8'd128;
   localparam logic [HYS_W-1:0]  HYS_RESET  = 6'd2;
   localparam logic [CAL_W-1:0]  REST_RESET = 12'hFFF;
   localparam logic [CAL_W-1:0]  BOT_RESET  = 12'h000;

   // trigger_mode codes; code 3 behaves as plain rapid trigger
   localparam logic [MODE_W-1:0] MODE_STANDARD   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RAPID      = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CONTINUOUS = 2'd2;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_THRESHOLD  = 3'd0,
      REG_HYSTERESIS = 3'd1,
      REG_MODE       = 3'd2,
      REG_REST       = 3'd3,
      REG_BOTTOM     = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic [THR_W-1:0]  press_threshold;
      logic [HYS_W-1:0]  hysteresis;
      logic [MODE_W-1:0] trigger_mode;
      logic [CAL_W-1:0]  cal_rest;
      logic [CAL_W-1:0]  cal_bottom;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_EMIT
   } bk_state_type;

endpackage

// ----- rtl/akrt_if.sv -----
// Interfaces: sample, result and register write channels.
`timescale 1ns / 1ps

interface akrt_req_if #(parameter int SAMPLE_BITS = akrt_pkg::SAMPLE_BITS_DEF);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] adc_sample;
   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

interface akrt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [akrt_pkg::TRAVEL_W-1:0]     travel;
   logic                              pressed;
   modport source (output valid, output travel, output pressed, input ready);
   modport sink   (input valid, input travel, input pressed, output ready);
endinterface

interface akrt_csr_if;
   logic                              valid;
   logic                              ready;
   logic [akrt_pkg::CSR_IDX_W-1:0]    reg_index;
   logic [akrt_pkg::CSR_DATA_W-1:0]   wr_data;
   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ----- rtl/akrt_front.sv -----
// Front end: takes samples, forms scaled numerator and divisor magnitudes and signs.
`timescale 1ns / 1ps

module akrt_front #(
   parameter int SAMPLE_BITS = akrt_pkg::SAMPLE_BITS_DEF,
   parameter int VAL_W       = akrt_pkg::CAL_W,
   parameter int NUM_W       = akrt_pkg::NUM_W_DEF,
   parameter int ENTRY_W     = akrt_pkg::ENTRY_W_DEF
) (
   akrt_req_if.sink              req_if,
   input  akrt_pkg::cfg_type     cfg,
   input  akrt_pkg::q_stat_type  q_stat,
   output logic                  push,
   output logic [ENTRY_W-1:0]    push_data
);

   localparam int CW = akrt_pkg::CAL_W;

   logic [VAL_W:0]   adc_ext;
   logic [VAL_W:0]   bot_ext;
   logic [VAL_W:0]   diff;
   logic [VAL_W-1:0] diff_mag;
   logic [NUM_W-1:0] num_mag;
   logic [CW:0]      den;
   logic [CW-1:0]    den_mag;
   logic             den_zero;
   logic             q_neg;

   always_comb begin
      adc_ext  = (VAL_W+1)'(req_if.adc_sample);
      bot_ext  = (VAL_W+1)'(cfg.cal_bottom);
      diff     = adc_ext - bot_ext;
      diff_mag = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];
      // times 255 as shift and subtract
      num_mag  = {diff_mag, 8'h00} - NUM_W'(diff_mag);
      den      = {1'b0, cfg.cal_rest} - {1'b0, cfg.cal_bottom};
      den_mag  = den[CW] ? CW'(-den) : den[CW-1:0];
      den_zero = (den == '0);
      q_neg    = diff[VAL_W] ^ den[CW];
   end

   assign req_if.ready = !q_stat.full;
   assign push         = req_if.valid && !q_stat.full;
   assign push_data    = {q_neg, den_zero, den_mag, num_mag};

endmodule

// ----- rtl/akrt_queue.sv -----
// Short word queue between the front end and the divide/trigger back end.
`timescale 1ns / 1ps

module akrt_queue #(
   parameter int DATA_W = akrt_pkg::ENTRY_W_DEF,
   parameter int DEPTH  = akrt_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_W-1:0]    push_data,
   input  logic                 pop,
   output logic [DATA_W-1:0]    pop_data,
   output akrt_pkg::q_stat_type q_stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
   endfunction

   always_comb begin
      q_stat.full  = (count_ff == CNT_W'(DEPTH));
      q_stat.empty = (count_ff == '0);
      do_push      = push && !q_stat.full;
      do_pop       = pop && !q_stat.empty;
      wr_ptr_in    = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in    = do_pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in     = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
      pop_data     = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/akrt_back.sv -----
// Back end: serial restoring divider, travel clamp, trigger state and result register.
`timescale 1ns / 1ps

module akrt_back #(
   parameter int NUM_W   = akrt_pkg::NUM_W_DEF,
   parameter int ENTRY_W = akrt_pkg::ENTRY_W_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  akrt_pkg::cfg_type    cfg,
   input  akrt_pkg::q_stat_type q_stat,
   input  logic [ENTRY_W-1:0]   pop_data,
   output logic                 pop,
   akrt_rsp_if.source           rsp_if
);

   localparam int CW    = akrt_pkg::CAL_W;
   localparam int TW    = akrt_pkg::TRAVEL_W;
   localparam int HW    = akrt_pkg::HYS_W;
   localparam int CNT_W = $clog2(NUM_W + 1);

   akrt_pkg::bk_state_type state_ff, state_in;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CW-1:0]    rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [CW-1:0]    den_ff, den_in;
   logic             neg_ff, neg_in;
   logic             zero_ff, zero_in;

   logic             key_down_ff, key_down_in;
   logic             armed_ff, armed_in;
   logic [TW-1:0]    extreme_ff, extreme_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0]    rsp_travel_ff, rsp_travel_in;
   logic             rsp_pressed_ff, rsp_pressed_in;

   logic [CW:0]      rem_sh;
   logic             fits;
   logic [TW-1:0]    travel;
   logic             out_free;

   // trigger next-state temporaries
   logic [TW:0]      t9;
   logic [TW:0]      arm_level;
   logic [TW-1:0]    release_lvl;
   logic [HW:0]      band;
   logic             kd;
   logic             arm;
   logic [TW-1:0]    ext;
   logic             kd_tr;
   logic             arm_tr;
   logic [TW-1:0]    ext_tr;

   // one restoring step per cycle
   always_comb begin
      rem_sh = {rem_ff, quo_ff[NUM_W-1]};
      fits   = (rem_sh >= {1'b0, den_ff});
   end

   // travel = 255 - quotient, clamped
   always_comb begin
      if (zero_ff) begin
         travel = '0;
      end else if (neg_ff) begin
         travel = akrt_pkg::TRAVEL_MAX;
      end else if (quo_ff > NUM_W'(akrt_pkg::TRAVEL_MAX)) begin
         travel = '0;
      end else begin
         travel = akrt_pkg::TRAVEL_MAX - quo_ff[TW-1:0];
      end
   end

   // rapid and continuous trigger update for this travel value
   always_comb begin
      t9        = {1'b0, travel};
      arm_level = {1'b0, cfg.press_threshold} + (TW+1)'(cfg.hysteresis);
      band      = {cfg.hysteresis, 1'b0};
      if (cfg.trigger_mode == akrt_pkg::MODE_CONTINUOUS) begin
         release_lvl = akrt_pkg::CONT_RELEASE;
      end else if (cfg.press_threshold > TW'(cfg.hysteresis)) begin
         release_lvl = cfg.press_threshold - TW'(cfg.hysteresis);
      end else begin
         release_lvl = '0;
      end

      kd  = key_down_ff;
      arm = armed_ff;
      ext = extreme_ff;
      if (!arm && (t9 > arm_level)) begin
         kd  = 1'b1;
         arm = 1'b1;
         ext = travel;
      end
      if (arm && (travel < release_lvl)) begin
         kd  = 1'b0;
         arm = 1'b0;
      end
      if (arm) begin
         if (kd) begin
            if (travel > ext) begin
               ext = travel;
            end
            if ((TW+1)'(ext - travel) > (TW+1)'(band)) begin
               kd  = 1'b0;
               ext = travel;
            end
         end else begin
            if (travel < ext) begin
               ext = travel;
            end
            if ((TW+1)'(travel - ext) > (TW+1)'(band)) begin
               kd  = 1'b1;
               ext = travel;
            end
         end
      end
      kd_tr  = kd;
      arm_tr = arm;
      ext_tr = ext;
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      den_in         = den_ff;
      neg_in         = neg_ff;
      zero_in        = zero_ff;
      key_down_in    = key_down_ff;
      armed_in       = armed_ff;
      extreme_in     = extreme_ff;
      out_free       = !rsp_valid_ff || rsp_if.ready;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_travel_in  = rsp_travel_ff;
      rsp_pressed_in = rsp_pressed_ff;
      pop            = 1'b0;

      unique case (state_ff)
         akrt_pkg::BK_IDLE: begin
            if (!q_stat.empty) begin
               pop      = 1'b1;
               {neg_in, zero_in, den_in, quo_in} = pop_data;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = akrt_pkg::BK_DIV;
            end
         end
         akrt_pkg::BK_DIV: begin
            rem_in = fits ? CW'(rem_sh - {1'b0, den_ff}) : rem_sh[CW-1:0];
            quo_in = {quo_ff[NUM_W-2:0], fits};
            cnt_in = CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               state_in = akrt_pkg::BK_EMIT;
            end
         end
         akrt_pkg::BK_EMIT: begin
            if (out_free) begin
               if (cfg.trigger_mode == akrt_pkg::MODE_STANDARD) begin
                  if (key_down_ff) begin
                     key_down_in = (cfg.press_threshold < TW'(cfg.hysteresis)) ||
                                   (t9 > ({1'b0, cfg.press_threshold} -
                                          (TW+1)'(cfg.hysteresis)));
                  end else begin
                     key_down_in = (t9 > arm_level);
                  end
               end else begin
                  key_down_in = kd_tr;
                  armed_in    = arm_tr;
                  extreme_in  = ext_tr;
               end
               rsp_valid_in   = 1'b1;
               rsp_travel_in  = travel;
               rsp_pressed_in = key_down_in;
               state_in       = akrt_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = akrt_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= akrt_pkg::BK_IDLE;
         key_down_ff  <= 1'b0;
         armed_ff     <= 1'b0;
         extreme_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_down_ff  <= key_down_in;
         armed_ff     <= armed_in;
         extreme_ff   <= extreme_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff         <= cnt_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      den_ff         <= den_in;
      neg_ff         <= neg_in;
      zero_ff        <= zero_in;
      rsp_travel_ff  <= rsp_travel_in;
      rsp_pressed_ff <= rsp_pressed_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.travel  = rsp_travel_ff;
   assign rsp_if.pressed = rsp_pressed_ff;

endmodule

// ----- rtl/analog_key_rapid_trigger.sv -----
// Top level: analog key channel with threshold and rapid trigger actuation.
`timescale 1ns / 1ps

// Usage
//   req_if : one word per converter sample (adc_sample, SAMPLE_BITS wide).
//   rsp_if : one word per sample: travel (0 at rest, 255 bottomed) and pressed.
//   csr_if : register writes, always ready; index 0 threshold, 1 hysteresis,
//            2 trigger mode, 3 rest count, 4 bottom count. Write only while idle.
// Timing
//   A sample is taken into a two-word queue, then the back end runs a
//   restoring divider one quotient bit per cycle over max(SAMPLE_BITS, 12)+8
//   bits (numerator is the sample offset times 255). With 12-bit samples the
//   back end works on one sample at a time: pop, 20 divide steps, write-out;
//   the queue takes further samples meanwhile.
// Stall
//   The result register holds a finished word while rsp_if.ready is low; the
//   back end waits in its write-out step and the queue keeps taking samples
//   until it holds two, then req_if.ready drops.
// Reset
//   Synchronous, active high. Clears queue, divider control, key state and
//   result valid; registers return to threshold 128, hysteresis 2, standard
//   mode, rest 4095 masked to the sample width, bottom 0.
module analog_key_rapid_trigger #(
   parameter int SAMPLE_BITS = akrt_pkg::SAMPLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   akrt_req_if.sink    req_if,
   akrt_rsp_if.source  rsp_if,
   akrt_csr_if.sink    csr_if
);

   localparam int CW      = akrt_pkg::CAL_W;
   // operand width: widest of sample and calibration counts
   localparam int VAL_W   = (SAMPLE_BITS > CW) ? SAMPLE_BITS : CW;
   localparam int NUM_W   = VAL_W + 8;
   localparam int ENTRY_W = NUM_W + CW + 2;
   // calibration bits above the sample width are dropped
   localparam logic [CW-1:0] CAL_MASK =
      (SAMPLE_BITS >= CW) ? {CW{1'b1}} : CW'((1 << SAMPLE_BITS) - 1);

   akrt_pkg::cfg_type    cfg_ff, cfg_in;
   akrt_pkg::q_stat_type q_stat;
   logic                 push;
   logic [ENTRY_W-1:0]   push_data;
   logic                 pop;
   logic [ENTRY_W-1:0]   pop_data;

   // register writes
   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.reg_index)
            akrt_pkg::REG_THRESHOLD:
               cfg_in.press_threshold = csr_if.wr_data[akrt_pkg::THR_W-1:0];
            akrt_pkg::REG_HYSTERESIS:
               cfg_in.hysteresis = csr_if.wr_data[akrt_pkg::HYS_W-1:0];
            akrt_pkg::REG_MODE:
               cfg_in.trigger_mode = csr_if.wr_data[akrt_pkg::MODE_W-1:0];
            akrt_pkg::REG_REST:
               cfg_in.cal_rest = csr_if.wr_data[CW-1:0] & CAL_MASK;
            akrt_pkg::REG_BOTTOM:
               cfg_in.cal_bottom = csr_if.wr_data[CW-1:0] & CAL_MASK;
            default: begin
               cfg_in = cfg_ff;   // unknown index: write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_threshold <= akrt_pkg::THR_RESET;
         cfg_ff.hysteresis      <= akrt_pkg::HYS_RESET;
         cfg_ff.trigger_mode    <= akrt_pkg::MODE_STANDARD;
         cfg_ff.cal_rest        <= akrt_pkg::REST_RESET & CAL_MASK;
         cfg_ff.cal_bottom      <= akrt_pkg::BOT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept and classify
   akrt_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .VAL_W       (VAL_W),
      .NUM_W       (NUM_W),
      .ENTRY_W     (ENTRY_W)
   ) u_front (
      .req_if    (req_if),
      .cfg       (cfg_ff),
      .q_stat    (q_stat),
      .push      (push),
      .push_data (push_data)
   );

   // decoupling queue
   akrt_queue #(
      .DATA_W (ENTRY_W),
      .DEPTH  (akrt_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_stat    (q_stat)
   );

   // back: divide, clamp, trigger, result register
   akrt_back #(
      .NUM_W   (NUM_W),
      .ENTRY_W (ENTRY_W)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_stat   (q_stat),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

   // checks
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("result valid right after reset");

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue both full and empty");

   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |-> !q_stat.full)
      else $error("sample accepted into a full queue");

   a_pop_needs_word: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("pop from an empty queue");

endmodule
